// ===== rtl/tmav_pkg.sv =====
// ----------------------------------------------------------------------------
// tmav_pkg
// Shared widths, types and scaling constants for the trimmed-mean voltage
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmav_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 18;
  localparam int COUNT_W  = 6;
  localparam int VOLT_W   = 6;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [VOLT_W-1:0]   volt_t;

  // Smallest-sample register starts at full scale.
  localparam sample_t SMALLEST_RESET = '1;

  // volts = floor(mean * VOLT_MUL / VOLT_DIV)
  localparam int VMUL_W   = 16;
  localparam int VDIV_W   = 22;
  localparam int VPROD_W  = SAMPLE_W + VMUL_W;
  localparam logic [VMUL_W-1:0] VOLT_MUL = 16'd39006;
  localparam logic [VDIV_W-1:0] VOLT_DIV = 22'd4095000;

  // Reciprocal of VOLT_DIV scaled by 2^VPROD_W, floored.
  localparam int VRECIP_W = 7;
  localparam logic [VRECIP_W-1:0] VOLT_RECIP =
    VRECIP_W'((64'd1 << VPROD_W) / 64'd4095000);

endpackage

`default_nettype wire

// ===== rtl/tmav_if.sv =====
// ----------------------------------------------------------------------------
// tmav_in_if / tmav_out_if
// Valid/ready channels for converter samples and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmav_in_if;
  logic              valid;
  logic              ready;
  tmav_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tmav_out_if;
  logic              valid;
  logic              ready;
  tmav_pkg::sample_t trimmed_mean;
  tmav_pkg::volt_t   volts;

  modport source (output valid, output trimmed_mean, output volts, input ready);
  modport sink   (input valid, input trimmed_mean, input volts, output ready);
endinterface

`default_nettype wire

// ===== rtl/tmav_window.sv =====
// ----------------------------------------------------------------------------
// tmav_window
// Window accumulator: sum, largest and smallest over SAMPLES samples; emits
// the trimmed sum (sum minus largest minus smallest) on the closing sample.
// ----------------------------------------------------------------------------
`default_nettype none

module tmav_window #(
  parameter int SAMPLES = 22
) (
  input  logic            clk,
  input  logic            rst_n,
  tmav_in_if.sink         in_bus,
  output logic            trim_valid,
  input  logic            trim_ready,
  output tmav_pkg::sum_t  trim_data
);
  import tmav_pkg::*;

  localparam count_t LAST = COUNT_W'(SAMPLES - 1);

  count_t  count_r;
  sum_t    sum_r;
  sample_t largest_r;
  sample_t smallest_r;
  logic    trim_valid_r;
  sum_t    trim_r;

  logic    last;
  logic    accept;
  sum_t    sum_nxt;
  sample_t largest_nxt;
  sample_t smallest_nxt;
  sum_t    trim_nxt;

  assign last   = (count_r == LAST);
  // Only the closing sample needs room in the trimmed-sum register.
  assign in_bus.ready = !last || !trim_valid_r || trim_ready;
  assign accept = in_bus.valid && in_bus.ready;

  assign sum_nxt      = sum_r + SUM_W'(in_bus.sample);
  assign largest_nxt  = (in_bus.sample > largest_r)  ? in_bus.sample : largest_r;
  assign smallest_nxt = (in_bus.sample < smallest_r) ? in_bus.sample : smallest_r;
  assign trim_nxt     = sum_nxt - SUM_W'(largest_nxt) - SUM_W'(smallest_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sum_r        <= '0;
      largest_r    <= '0;
      smallest_r   <= SMALLEST_RESET;
      trim_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          count_r    <= '0;
          sum_r      <= '0;
          largest_r  <= '0;
          smallest_r <= SMALLEST_RESET;
        end else begin
          count_r    <= count_r + 1'b1;
          sum_r      <= sum_nxt;
          largest_r  <= largest_nxt;
          smallest_r <= smallest_nxt;
        end
      end
      if (accept && last) begin
        trim_valid_r <= 1'b1;
      end else if (trim_ready) begin
        trim_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      trim_r <= trim_nxt;
    end
  end

  assign trim_valid = trim_valid_r;
  assign trim_data  = trim_r;

  // Closing sample leaves a cleared window and a pending trimmed beat.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (count_r == '0 && trim_valid_r))
    else $error("window did not close cleanly");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST)
    else $error("sample count past window length");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (smallest_r <= largest_r))
    else $error("smallest exceeds largest in open window");

endmodule

`default_nettype wire

// ===== rtl/trimmed_mean_adc_voltage.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_adc_voltage
// Olympic trimmed-mean filter over windows of SAMPLES converter samples,
// with scaling of the mean to whole volts.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_bus    in    valid/ready    sample[11:0]
//   out_bus   out   valid/ready    trimmed_mean[11:0], volts[5:0]
//
// One sample beat per cycle. Once the closing sample of a window is accepted,
// out_bus.valid rises after the trimmed-sum register and five scaling stages
// (reciprocal multiply, correction, volt multiply, reciprocal
// multiply, correction). rst_n is synchronous, active low; it clears the
// window and all stage valids. in_bus.ready drops only on a closing sample
// while the trimmed-sum register and the pipe behind it are stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_adc_voltage #(
  parameter int SAMPLES = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  tmav_in_if.sink     in_bus,
  tmav_out_if.source  out_bus
);
  import tmav_pkg::*;

  // Divide by SAMPLES-2 through a floored reciprocal scaled by 2^SUM_W;
  // the estimate is exact or one short, fixed by one compare.
  localparam count_t MEAN_DIV = COUNT_W'(SAMPLES - 2);
  localparam logic [SUM_W:0] MEAN_RECIP = (SUM_W + 1)'((1 << SUM_W) / (SAMPLES - 2));
  localparam int P1_W  = 2 * SUM_W + 1;
  localparam int QD1_W = SUM_W + COUNT_W;
  localparam int P2_W  = VPROD_W + VRECIP_W;
  localparam int QD2_W = VRECIP_W + VDIV_W;

  // window -> stage 1
  logic trim_valid;
  logic trim_ready;
  sum_t trim_data;

  tmav_window #(.SAMPLES(SAMPLES)) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .trim_valid (trim_valid),
    .trim_ready (trim_ready),
    .trim_data  (trim_data)
  );

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_bus.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign trim_ready = rdy1;

  // stage 1: trimmed sum times reciprocal
  sum_t             trim1_r;
  logic [P1_W-1:0]  p1_r;

  // stage 2: corrected mean
  logic [SUM_W-1:0] qe1;
  logic [QD1_W-1:0] qd1;
  sum_t             rem1;
  sum_t             mean_full;
  sample_t          mean2_r;

  assign qe1       = p1_r[P1_W-2:SUM_W];
  assign qd1       = QD1_W'(qe1) * QD1_W'(MEAN_DIV);
  assign rem1      = trim1_r - qd1[SUM_W-1:0];
  assign mean_full = qe1 + SUM_W'(rem1 >= SUM_W'(MEAN_DIV));

  // stage 3: mean times volt numerator
  sample_t            mean3_r;
  logic [VPROD_W-1:0] vprod3_r;

  // stage 4: volt product times reciprocal of volt denominator
  sample_t            mean4_r;
  logic [VPROD_W-1:0] vprod4_r;
  logic [P2_W-1:0]    p2_r;

  // stage 5: corrected volts, output register
  logic [VRECIP_W-1:0] qe2;
  logic [QD2_W-1:0]    qd2;
  logic [VPROD_W-1:0]  rem2;
  logic [VRECIP_W-1:0] volts_full;
  sample_t             mean5_r;
  volt_t               volts5_r;

  assign qe2        = p2_r[P2_W-1:VPROD_W];
  assign qd2        = QD2_W'(qe2) * QD2_W'(VOLT_DIV);
  assign rem2       = vprod4_r - qd2[VPROD_W-1:0];
  assign volts_full = qe2 + VRECIP_W'(rem2 >= VPROD_W'(VOLT_DIV));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= trim_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && trim_valid) begin
      trim1_r <= trim_data;
      p1_r    <= P1_W'(trim_data) * P1_W'(MEAN_RECIP);
    end
    if (rdy2 && v1_r) begin
      mean2_r <= mean_full[SAMPLE_W-1:0];
    end
    if (rdy3 && v2_r) begin
      mean3_r  <= mean2_r;
      vprod3_r <= VPROD_W'(mean2_r) * VPROD_W'(VOLT_MUL);
    end
    if (rdy4 && v3_r) begin
      mean4_r  <= mean3_r;
      vprod4_r <= vprod3_r;
      p2_r     <= P2_W'(vprod3_r) * P2_W'(VOLT_RECIP);
    end
    if (rdy5 && v4_r) begin
      mean5_r  <= mean4_r;
      volts5_r <= volts_full[VOLT_W-1:0];
    end
  end

  assign out_bus.valid        = v5_r;
  assign out_bus.trimmed_mean = mean5_r;
  assign out_bus.volts        = volts5_r;

  // Result volts are the floor of the scaled mean.
  a_volts_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |->
      (64'(out_bus.trimmed_mean) * 64'(VOLT_MUL) >= 64'(out_bus.volts) * 64'(VOLT_DIV)))
    else $error("volts above scaled mean");

  a_volts_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |->
      (64'(out_bus.trimmed_mean) * 64'(VOLT_MUL) <
       (64'(out_bus.volts) + 64'd1) * 64'(VOLT_DIV)))
    else $error("volts below floor of scaled mean");

  // A waiting result beat holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.ready) |=>
      (out_bus.valid && $stable(out_bus.trimmed_mean) && $stable(out_bus.volts)))
    else $error("result beat changed while stalled");

endmodule

`default_nettype wire
